// ===== rtl/json_token_syntax_checker_defines.svh =====
// assertion helpers shared by the rtl
`ifndef JSON_TOKEN_SYNTAX_CHECKER_DEFINES_SVH
`define JSON_TOKEN_SYNTAX_CHECKER_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define JTSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JTSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jtsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jtsc_pkg;

  typedef enum logic [3:0] {
    TK_LBRACK = 4'd0,
    TK_RBRACK = 4'd1,
    TK_LBRACE = 4'd2,
    TK_RBRACE = 4'd3,
    TK_COMMA  = 4'd4,
    TK_COLON  = 4'd5,
    TK_STRING = 4'd6,
    TK_NUMBER = 4'd7,
    TK_TRUE   = 4'd8,
    TK_FALSE  = 4'd9,
    TK_NULL   = 4'd10
  } tok_t;

  typedef enum logic [3:0] {
    PH_TOP       = 4'd0,
    PH_ARR_FIRST = 4'd1,
    PH_OBJ_FIRST = 4'd2,
    PH_KEY_COLON = 4'd3,
    PH_OBJ_VALUE = 4'd4,
    PH_OBJ_NEXT  = 4'd5,
    PH_OBJ_KEY   = 4'd6,
    PH_ARR_NEXT  = 4'd7,
    PH_ARR_ELEM  = 4'd8,
    PH_DONE      = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SYNTAX = 2'd1,
    ERR_DEPTH  = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    EXP_NONE             = 4'd0,
    EXP_VALUE            = 4'd1,
    EXP_STRING           = 4'd2,
    EXP_OPEN             = 4'd3,
    EXP_OPEN_OR_RBRACK   = 4'd4,
    EXP_STRING_OR_RBRACE = 4'd5,
    EXP_COLON            = 4'd6,
    EXP_RBRACK           = 4'd7,
    EXP_RBRACE           = 4'd8
  } exp_t;

  localparam int unsigned DEPTH_W = 7;

  typedef struct packed {
    logic               ok;
    err_t               err;
    exp_t               cls;
    logic [DEPTH_W-1:0] depth;
    logic               done;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/jtsc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jtsc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/json_token_syntax_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | signals                                   | dir | transfer when
// ---------+-------------------------------------------+-----+----------------------------
// token in | in_valid, in_stall, token_kind,           | in  | in_valid && !in_stall
//          | new_document                              |     |
// result   | out_valid, out_stall, token_ok,           | out | out_valid && !out_stall
//          | error_kind, expected_class,               |     |
//          | nesting_depth, document_complete          |     |
//
// one token per cycle while in_stall is low, one result per token; each result is registered
// the phase update and a single push or pop complete on acceptance; the entry below the top
// of the context stack is prefetched from the stack memory each cycle so a close never waits
// synchronous reset clears phase, stack pointer and sticky error; no clearing pass needed
// a result register plus one skid entry: in_stall rises only once the skid entry is full

`include "json_token_syntax_checker_defines.svh"

module json_token_syntax_checker #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [3:0]                  token_kind,
  input  wire logic                        new_document,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic                        token_ok,
  output      logic [1:0]                  error_kind,
  output      logic [3:0]                  expected_class,
  output      logic [jtsc_pkg::DEPTH_W-1:0] nesting_depth,
  output      logic                        document_complete
);

  import jtsc_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_DEPTH);
  localparam int unsigned SPW = $clog2(MAX_DEPTH + 1);

  // grammar state
  phase_t         phase, phase_next;
  logic [SPW-1:0] sp, sp_next;
  err_t           serr, serr_next;
  exp_t           sexp, sexp_next;

  // effective state once a new document has been applied
  phase_t         eff_phase;
  logic [SPW-1:0] eff_sp;
  err_t           eff_err;
  exp_t           eff_exp;

  logic           in_acc;
  logic           opener, scalar, is_obj;
  logic           push_req, pop_req, move_ok;
  phase_t         move_phase;
  exp_t           exp_code;
  err_t           step_err;
  logic           commit;
  logic [SPW-1:0] sp_dec, sp_m2;
  logic           held_acc, depth_hit;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic           below_obj;

  res_t                   res_new, out_r, skid_r;
  logic                   skid_valid;
  logic                   out_take;
  logic [SPW+DEPTH_W-1:0] depth_wide;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  assign eff_phase = new_document ? PH_TOP : phase;
  assign eff_sp    = new_document ? '0 : sp;
  assign eff_err   = new_document ? ERR_NONE : serr;
  assign eff_exp   = new_document ? EXP_NONE : sexp;

  assign opener = (token_kind == TK_LBRACK) || (token_kind == TK_LBRACE);
  assign is_obj = (token_kind == TK_LBRACE);
  assign scalar = (token_kind == TK_STRING) || (token_kind == TK_NUMBER) ||
                  (token_kind == TK_TRUE) || (token_kind == TK_FALSE) ||
                  (token_kind == TK_NULL);

  // decode: what the current phase expects and what this token does
  always_comb begin
    push_req   = 1'b0;
    pop_req    = 1'b0;
    move_ok    = 1'b0;
    move_phase = eff_phase;
    exp_code   = EXP_NONE;
    unique case (eff_phase) inside
      PH_TOP, PH_ARR_ELEM: begin
        exp_code = EXP_OPEN;
        push_req = opener;
      end
      PH_ARR_FIRST: begin
        exp_code = EXP_OPEN_OR_RBRACK;
        push_req = opener;
        pop_req  = (token_kind == TK_RBRACK);
      end
      PH_OBJ_FIRST: begin
        exp_code   = EXP_STRING_OR_RBRACE;
        move_ok    = (token_kind == TK_STRING);
        move_phase = PH_KEY_COLON;
        pop_req    = (token_kind == TK_RBRACE);
      end
      PH_OBJ_KEY: begin
        exp_code   = EXP_STRING;
        move_ok    = (token_kind == TK_STRING);
        move_phase = PH_KEY_COLON;
      end
      PH_KEY_COLON: begin
        exp_code   = EXP_COLON;
        move_ok    = (token_kind == TK_COLON);
        move_phase = PH_OBJ_VALUE;
      end
      PH_OBJ_VALUE: begin
        exp_code   = EXP_VALUE;
        push_req   = opener;
        move_ok    = scalar;
        move_phase = PH_OBJ_NEXT;
      end
      PH_OBJ_NEXT: begin
        exp_code   = EXP_RBRACE;
        move_ok    = (token_kind == TK_COMMA);
        move_phase = PH_OBJ_KEY;
        pop_req    = (token_kind == TK_RBRACE);
      end
      PH_ARR_NEXT: begin
        exp_code   = EXP_RBRACK;
        move_ok    = (token_kind == TK_COMMA);
        move_phase = PH_ARR_ELEM;
        pop_req    = (token_kind == TK_RBRACK);
      end
      PH_DONE: begin
        exp_code = EXP_NONE;
      end
      default: begin
        exp_code = EXP_NONE;
      end
    endcase

    if (push_req) begin
      step_err = (eff_sp >= SPW'(MAX_DEPTH)) ? ERR_DEPTH : ERR_NONE;
    end else if (pop_req || move_ok) begin
      step_err = ERR_NONE;
    end else begin
      step_err = ERR_SYNTAX;
    end
  end

  assign commit = in_acc && (eff_err == ERR_NONE) && (step_err == ERR_NONE);
  assign sp_dec = (eff_sp == '0) ? '0 : eff_sp - SPW'(1);

  // next state
  always_comb begin
    phase_next = phase;
    sp_next    = sp;
    serr_next  = serr;
    sexp_next  = sexp;
    if (in_acc) begin
      phase_next = eff_phase;
      sp_next    = eff_sp;
      serr_next  = eff_err;
      sexp_next  = eff_exp;
      if (eff_err == ERR_NONE) begin
        if (step_err != ERR_NONE) begin
          serr_next = step_err;
          sexp_next = (step_err == ERR_SYNTAX) ? exp_code : EXP_NONE;
        end else if (push_req) begin
          sp_next    = eff_sp + SPW'(1);
          phase_next = is_obj ? PH_OBJ_FIRST : PH_ARR_FIRST;
        end else if (pop_req) begin
          sp_next = sp_dec;
          if (sp_dec == '0) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = below_obj ? PH_OBJ_NEXT : PH_ARR_NEXT;
          end
        end else begin
          phase_next = move_phase;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TOP;
      sp    <= '0;
      serr  <= ERR_NONE;
      sexp  <= EXP_NONE;
    end else begin
      phase <= phase_next;
      sp    <= sp_next;
      serr  <= serr_next;
      sexp  <= sexp_next;
    end
  end

  // context stack: push writes at the old pointer, the read port always fetches
  // the entry two below the next pointer, i.e. the context uncovered by a close
  assign ram_we    = commit && push_req;
  assign ram_waddr = eff_sp[AW-1:0];
  assign sp_m2     = sp_next - SPW'(2);
  assign ram_raddr = sp_m2[AW-1:0];

  jtsc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (is_obj),
    .raddr (ram_raddr),
    .rdata (below_obj)
  );

  // result for this token
  assign depth_wide = {{DEPTH_W{1'b0}}, sp_next};

  always_comb begin
    res_new.ok    = commit;
    res_new.err   = serr_next;
    res_new.cls   = sexp_next;
    res_new.depth = depth_wide[DEPTH_W-1:0];
    res_new.done  = (phase_next == PH_DONE);
  end

  // result register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (out_valid && !out_take) begin
        skid_r <= res_new;
      end else begin
        out_r <= res_new;
      end
    end
  end

  assign token_ok          = out_r.ok;
  assign error_kind        = out_r.err;
  assign expected_class    = out_r.cls;
  assign nesting_depth     = out_r.depth;
  assign document_complete = out_r.done;

  // transfer taken while an error is held, and a push refused for depth
  assign held_acc  = in_acc && !new_document && (serr != ERR_NONE);
  assign depth_hit = in_acc && (eff_err == ERR_NONE) && (step_err == ERR_DEPTH);

  `JTSC_ASSERT_IMPL(a_sp_bound, 1'b1, sp <= SPW'(MAX_DEPTH), "stack pointer beyond depth")
  `JTSC_ASSERT_IMPL(a_done_empty, phase == PH_DONE, sp == '0, "done with open context")
  `JTSC_ASSERT_IMPL(a_skid_order, skid_valid, out_valid, "skid entry held without a result")
  `JTSC_ASSERT_NEXT(a_sticky_hold, held_acc, $stable(phase) && $stable(sp), "held state moved")
  `JTSC_ASSERT_IMPL(a_depth_err, depth_hit, eff_sp == SPW'(MAX_DEPTH), "depth error below full")

endmodule

`default_nettype wire
